### rtl/core/chbd_pkg.sv
`timescale 1ns / 1ps

package chbd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FIN  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Queue depths between the parts
  localparam int unsigned CLS_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  // Characters the front classifies
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // One classified request, front to back
  typedef struct packed {
    logic       restart;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_x;
    logic       is_zero;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] data;
  } cls_t;

  // One result request, back to output queue
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

### rtl/core/chbd_fifo.sv
`timescale 1ns / 1ps

module chbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr;
  logic             do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/core/chbd_front.sv
`timescale 1ns / 1ps

module chbd_front import chbd_pkg::*; (
  input  logic       func_i,
  input  logic [7:0] in_byte_i,
  input  logic       push_i,
  input  logic       cls_full_i,
  output logic       cls_wr_o,
  output cls_t       cls_o
);

  logic is_dec;
  logic is_lhex;
  logic is_uhex;

  assign is_dec  = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
  assign is_lhex = (in_byte_i >= CH_LA) && (in_byte_i <= CH_LF_HX);
  assign is_uhex = (in_byte_i >= CH_UA) && (in_byte_i <= CH_UF);

  // Classify the byte once so the parser works from flags and the hex value
  always_comb begin
    cls_o.restart  = func_i;
    cls_o.is_space = (in_byte_i == CH_SPACE) ||
                     ((in_byte_i >= CH_TAB) && (in_byte_i <= CH_CR));
    cls_o.is_cr    = (in_byte_i == CH_CR);
    cls_o.is_lf    = (in_byte_i == CH_LF);
    cls_o.is_x     = (in_byte_i == CH_LX) || (in_byte_i == CH_UX);
    cls_o.is_zero  = (in_byte_i == CH_ZERO);
    cls_o.is_hex   = is_dec || is_lhex || is_uhex;
    cls_o.data     = in_byte_i;
    if (is_dec) begin
      cls_o.hex_val = in_byte_i[3:0];
    end else if (is_lhex || is_uhex) begin
      cls_o.hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      cls_o.hex_val = 4'd0;
    end
  end

  // Write into the class queue when there is room
  assign cls_wr_o = push_i && !cls_full_i;

endmodule

### rtl/core/chbd_back.sv
`timescale 1ns / 1ps

module chbd_back import chbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cls_valid_i,
  input  cls_t cls_i,
  output logic cls_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  typedef enum logic [3:0] {
    PH_LWS,
    PH_ZERO,
    PH_DIGITS,
    PH_IGNORE,
    PH_DATA,
    PH_SKIP,
    PH_TRAIL0,
    PH_DONE,
    PH_ERR
  } phase_e;

  localparam logic [SIZE_BITS-1:0] ONE = SIZE_BITS'(1);
  localparam logic [SIZE_BITS-1:0] TWO = SIZE_BITS'(2);

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 digit_q, digit_d;
  logic                 cr_q, cr_d;
  logic                 go;
  logic                 ovf;
  logic [SIZE_BITS-1:0] size_shift;
  logic [SIZE_BITS-1:0] left_dec;

  assign go         = cls_valid_i && !res_full_i;
  assign cls_pop_o  = go;
  assign ovf        = |size_q[SIZE_BITS-1 -: 4];
  assign size_shift = {size_q[SIZE_BITS-5:0], cls_i.hex_val};
  assign left_dec   = left_q - ONE;

  // Parse one classified byte per cycle while one is queued and the result queue has room
  always_comb begin
    phase_d    = phase_q;
    size_d     = size_q;
    left_d     = left_q;
    digit_d    = digit_q;
    cr_d       = cr_q;
    res_push_o = 1'b0;
    res_o      = '{kind: KIND_DATA, data: 8'd0, last: 1'b0};
    if (go) begin
      if (cls_i.restart) begin
        phase_d = PH_LWS;
        size_d  = '0;
        left_d  = '0;
        digit_d = 1'b0;
        cr_d    = 1'b0;
      end else begin
        case (phase_q)
          PH_DATA: begin
            left_d     = left_dec;
            res_push_o = 1'b1;
            res_o.data = cls_i.data;
            if (left_q == ONE) begin
              res_o.last = 1'b1;
              phase_d    = PH_SKIP;
              left_d     = TWO;
            end
          end
          PH_SKIP: begin
            left_d = left_dec;
            if (left_q == ONE) begin
              phase_d = PH_LWS;
              size_d  = '0;
              digit_d = 1'b0;
              cr_d    = 1'b0;
            end
          end
          PH_TRAIL0: begin
            left_d = left_dec;
            if (left_q == ONE) begin
              phase_d    = PH_DONE;
              res_push_o = 1'b1;
              res_o.kind = KIND_FIN;
            end
          end
          PH_LWS, PH_ZERO, PH_DIGITS, PH_IGNORE: begin
            if (cr_q && cls_i.is_lf) begin
              // End of size line
              cr_d = 1'b0;
              if (!digit_q) begin
                phase_d    = PH_ERR;
                res_push_o = 1'b1;
                res_o.kind = KIND_ERR;
              end else if (size_q == '0) begin
                phase_d = PH_TRAIL0;
                left_d  = TWO;
              end else begin
                phase_d = PH_DATA;
                left_d  = size_q;
              end
            end else begin
              cr_d = cls_i.is_cr;
              case (phase_q)
                PH_LWS: begin
                  if (cls_i.is_space) begin
                    phase_d = PH_LWS;
                  end else if (cls_i.is_zero) begin
                    digit_d = 1'b1;
                    phase_d = PH_ZERO;
                  end else if (cls_i.is_hex) begin
                    size_d  = size_shift;
                    digit_d = 1'b1;
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_IGNORE;
                  end
                end
                PH_ZERO: begin
                  if (cls_i.is_x) begin
                    phase_d = PH_DIGITS;
                  end else if (cls_i.is_hex) begin
                    size_d  = size_shift;
                    digit_d = 1'b1;
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_IGNORE;
                  end
                end
                PH_DIGITS: begin
                  if (cls_i.is_hex) begin
                    if (ovf) begin
                      phase_d    = PH_ERR;
                      cr_d       = 1'b0;
                      res_push_o = 1'b1;
                      res_o.kind = KIND_ERR;
                    end else begin
                      size_d  = size_shift;
                      digit_d = 1'b1;
                    end
                  end else begin
                    phase_d = PH_IGNORE;
                  end
                end
                default: phase_d = phase_q;
              endcase
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LWS;
      size_q  <= '0;
      left_q  <= '0;
      digit_q <= 1'b0;
      cr_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      size_q  <= size_d;
      left_q  <= left_d;
      digit_q <= digit_d;
      cr_q    <= cr_d;
    end
  end

endmodule

### rtl/core/http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// Chunked HTTP body decoder. Feed the encoded body one byte per request on
// func_i/in_byte_i with push; a request is taken at a clock edge where push
// is high and full is low. func_i high restarts parsing of a new body and
// gives no result. Results leave through a queue: while empty is low the
// oldest result sits on kind_o/out_byte_o/chunk_last_o, and pop takes it.
// kind_o is data (out_byte_o valid, chunk_last_o on a chunk's final byte),
// finished, or size line error. Bytes that produce nothing are dropped.
// Throughput is one byte per cycle while pop keeps up: a classifier front
// end fills a CLS_DEPTH entry class queue, and the parser back end drains
// one entry per cycle, while the result queue has room, into a RES_DEPTH
// entry result queue. An accepted byte is registered in the class queue;
// the parser then writes its result into the result queue for pop. If pop
// stalls, the result queue fills, the parser stops, then the class queue
// fills and full rises; nothing is lost. Reset (rst_ni low, asynchronous)
// empties both queues and puts the parser back at the start of a size line.
// SIZE_BITS sets the largest chunk size accepted before an overflow error.
module http_chunked_body_decoder_unit import chbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       chunk_last_o
);

  cls_t cls_wdata;
  cls_t cls_rdata;
  logic cls_wr;
  logic cls_full;
  logic cls_empty;
  logic cls_pop;
  res_t res_wdata;
  res_t res_rdata;
  logic res_push;
  logic res_full;

  // Classify incoming bytes
  chbd_front u_front (
    .func_i     (func_i),
    .in_byte_i  (in_byte_i),
    .push_i     (push),
    .cls_full_i (cls_full),
    .cls_wr_o   (cls_wr),
    .cls_o      (cls_wdata)
  );

  // Decouple classifier from parser
  chbd_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (CLS_DEPTH)
  ) u_cls_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cls_wr),
    .wr_data_i (cls_wdata),
    .rd_en_i   (cls_pop),
    .rd_data_o (cls_rdata),
    .full_o    (cls_full),
    .empty_o   (cls_empty)
  );

  // Parse size lines and pass data through
  chbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (!cls_empty),
    .cls_i       (cls_rdata),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata)
  );

  // Hold results until popped
  chbd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_wdata),
    .rd_en_i   (pop),
    .rd_data_o (res_rdata),
    .full_o    (res_full),
    .empty_o   (empty)
  );

  assign full         = cls_full;
  assign kind_o       = res_rdata.kind;
  assign out_byte_o   = res_rdata.data;
  assign chunk_last_o = res_rdata.last;

`ifndef SYNTHESIS
  // Parser never writes a result into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result written while result queue full");

  // A restart request never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_pop && cls_rdata.restart) |-> !res_push)
    else $error("restart produced a result");

  // Parser only advances with a request present
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> cls_pop)
    else $error("result without a parsed request");

  // Chunk end marker only rides on data results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_last_o) |-> (kind_o == KIND_DATA))
    else $error("chunk end marker on a non-data result");
`endif

endmodule
